// ----- sv/lcdnw_pkg.sv -----
// Shared types, constants and the glyph remap for the character-LCD nibble writer.
// No dependencies; every other file in this block imports it.
package lcdnw_pkg;

  localparam int unsigned TicksW = 20;
  localparam logic [TicksW-1:0] PulseTicksReset = 20'd20000;

  // One input transaction: byte and data/command flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
  } in_item_t;

  // One output transaction: a single pin state on the LCD bus.
  typedef struct packed {
    logic [3:0]        data_nibble;
    logic              register_select;
    logic              enable_pin;
    logic [TicksW-1:0] hold_ticks;
    logic              last;
  } out_item_t;

  // Queued transfer after classification: the byte to put on the bus.
  typedef struct packed {
    logic [7:0] bus_byte;
    logic       rs;
  } xfer_t;

  // Pin-state sequence of one transfer, high nibble first.
  typedef enum logic [2:0] {
    PH_SETUP_HI  = 3'd0,
    PH_PULSE_HI  = 3'd1,
    PH_SETTLE_HI = 3'd2,
    PH_SETUP_LO  = 3'd3,
    PH_PULSE_LO  = 3'd4,
    PH_SETTLE_LO = 3'd5
  } phase_e;

  // Turkish letters (Windows-1254) onto custom glyph slots 0 to 4.
  function automatic logic [7:0] remap_glyph(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'hC7, 8'hE7: r = 8'd0;
      8'hDD, 8'hFD: r = 8'd1;
      8'hD6, 8'hF6: r = 8'd2;
      8'hDE, 8'hFE: r = 8'd3;
      8'hDC, 8'hFC: r = 8'd4;
      default:      r = b;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/lcdnw_front.sv -----
// Front stage: accepts transfers, applies the glyph remap to data bytes.
// Depends on lcdnw_pkg.
module lcdnw_front
  import lcdnw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  output xfer_t    push_data_o,
  input  logic     queue_full_i
);

  logic  valid_q, valid_d;
  xfer_t xfer_q;
  logic  accept;

  assign in_stall_o  = valid_q & queue_full_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign push_o      = valid_q & ~queue_full_i;
  assign push_data_o = xfer_q;
  assign valid_d     = accept | (valid_q & ~push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classify: remap data bytes only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xfer_q.rs       <= in_data_i.is_data;
      xfer_q.bus_byte <= in_data_i.is_data ? remap_glyph(in_data_i.data_byte)
                                           : in_data_i.data_byte;
    end
  end

endmodule

// ----- sv/lcdnw_queue.sv -----
// Short FIFO of classified transfers between front and back.
// Depends on lcdnw_pkg.
module lcdnw_queue
  import lcdnw_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  xfer_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output xfer_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  xfer_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/lcdnw_back.sv -----
// Back stage: walks the six pin states of the queued transfer into an output register.
// Depends on lcdnw_pkg.
module lcdnw_back
  import lcdnw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              queue_empty_i,
  input  xfer_t             head_i,
  output logic              pop_o,
  input  logic [TicksW-1:0] pulse_ticks_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  phase_e    phase_q, phase_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  out_item_t pin_state;
  logic      load;

  assign load  = ~queue_empty_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = load & (phase_q == PH_SETTLE_LO);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    if (load) begin
      case (phase_q)
        PH_SETUP_HI:  phase_d = PH_PULSE_HI;
        PH_PULSE_HI:  phase_d = PH_SETTLE_HI;
        PH_SETTLE_HI: phase_d = PH_SETUP_LO;
        PH_SETUP_LO:  phase_d = PH_PULSE_LO;
        PH_PULSE_LO:  phase_d = PH_SETTLE_LO;
        PH_SETTLE_LO: phase_d = PH_SETUP_HI;
        default:      phase_d = PH_SETUP_HI;
      endcase
    end
  end

  // Pin state for the current phase.
  always_comb begin
    pin_state.register_select = head_i.rs;
    pin_state.data_nibble     = head_i.bus_byte[7:4];
    pin_state.enable_pin      = 1'b0;
    pin_state.hold_ticks      = pulse_ticks_i;
    pin_state.last            = 1'b0;
    case (phase_q)
      PH_SETUP_HI: begin
        pin_state.hold_ticks = '0;
      end
      PH_PULSE_HI: begin
        pin_state.enable_pin = 1'b1;
      end
      PH_SETTLE_HI: begin
      end
      PH_SETUP_LO: begin
        pin_state.data_nibble = head_i.bus_byte[3:0];
        pin_state.hold_ticks  = '0;
      end
      PH_PULSE_LO: begin
        pin_state.data_nibble = head_i.bus_byte[3:0];
        pin_state.enable_pin  = 1'b1;
      end
      PH_SETTLE_LO: begin
        pin_state.data_nibble = head_i.bus_byte[3:0];
        pin_state.last        = 1'b1;
      end
      default: begin
        pin_state.hold_ticks = '0;
      end
    endcase
  end

  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SETUP_HI;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= pin_state;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/char_lcd_nibble_writer.sv -----
// Top level of the character-LCD 4-bit nibble writer.
// Depends on lcdnw_pkg, lcdnw_front, lcdnw_queue and lcdnw_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is
//   one LCD transfer, a byte and a data/command flag. Data bytes have the
//   Turkish letters remapped to custom glyphs 0 to 4; commands pass as is.
//   Output channel (out_valid_o / out_stall_i / out_data_o): each transfer
//   yields six transactions, one per pin state: setup, E high, E low for
//   the high nibble, then the same for the low nibble. The final one has
//   last set. hold_ticks carries the pulse length, 0 on the setup states.
//   Configuration: cfg_we_i writes cfg_wdata_i into the pulse length.
//   Path: an accepted transfer is registered in the front, written into the
//   queue, then loaded into the output register as its first pin state.
//   Throughput: set by the back-end sequencer that emits one pin state per cycle
//   while out_stall_i is low; the front and the queue take a transfer every cycle until the queue fills.
//   Reset: queue and sequencer empty, pulse length back to 20000 ticks.
//   A stalled receiver holds the output register; the back end then halts,
//   the queue fills and in_stall_o rises without losing any transaction.
module char_lcd_nibble_writer
  import lcdnw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [TicksW-1:0] cfg_wdata_i
);

  logic [TicksW-1:0] pulse_ticks_q;
  logic              push, pop, queue_full, queue_empty;
  xfer_t             push_data, head;

  // Pulse length register: write whenever enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= PulseTicksReset;
    end else if (cfg_we_i) begin
      pulse_ticks_q <= cfg_wdata_i;
    end
  end

  // Front: accept and classify the transfer.
  lcdnw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_full_i (queue_full)
  );

  // Decouple the front from the pin sequencer.
  lcdnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .head_o      (head)
  );

  // Back: advance through the six pin states, drop the transfer after the last.
  lcdnw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .head_i        (head),
    .pop_o         (pop),
    .pulse_ticks_i (pulse_ticks_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- tb/char_lcd_nibble_writer_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for char_lcd_nibble_writer: watches the transfer, pin-state and
// configuration ports, predicts six pin states per transfer and compares them.
// Depends on lcdnw_pkg only.
module char_lcd_nibble_writer_checker
  import lcdnw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_data_i,
  input  logic              cfg_we_i,
  input  logic [TicksW-1:0] cfg_wdata_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  logic [TicksW-1:0] pulse_len;
  out_item_t         expected_pins[$];

  // Upper and lower case forms differ only in bit 5, so fold them together.
  function automatic logic [7:0] lcd_glyph_code(input logic [7:0] b);
    logic [7:0] code;
    case (b | 8'h20)
      8'hE7:   code = 8'd0;
      8'hFD:   code = 8'd1;
      8'hF6:   code = 8'd2;
      8'hFE:   code = 8'd3;
      8'hFC:   code = 8'd4;
      default: code = b;
    endcase
    return code;
  endfunction

  function automatic void push_pin_states(input in_item_t t);
    logic [7:0] bus_byte;
    out_item_t  pin;
    phase_e     ph;
    bus_byte = t.is_data ? lcd_glyph_code(t.data_byte) : t.data_byte;
    for (int k = 0; k < 6; k++) begin
      ph                  = phase_e'(k);
      pin.data_nibble     = (k < 3) ? bus_byte[7:4] : bus_byte[3:0];
      pin.register_select = t.is_data;
      pin.enable_pin      = (ph == PH_PULSE_HI) || (ph == PH_PULSE_LO);
      pin.hold_ticks      = (ph == PH_SETUP_HI || ph == PH_SETUP_LO) ? '0 : pulse_len;
      pin.last            = (ph == PH_SETTLE_LO);
      expected_pins.push_back(pin);
    end
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  task automatic check_pin_state(input out_item_t got);
    out_item_t want;
    if (expected_pins.size() == 0) begin
      $display("%0t: pin state with no transfer pending, expected none, actual %p",
               $time, got);
      fail_count_o++;
    end else begin
      want = expected_pins.pop_front();
      compare_field("data_nibble", want.data_nibble, got.data_nibble);
      compare_field("register_select", want.register_select, got.register_select);
      compare_field("enable_pin", want.enable_pin, got.enable_pin);
      compare_field("hold_ticks", want.hold_ticks, got.hold_ticks);
      compare_field("last", want.last, got.last);
      checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pins.delete();
      pulse_len    <= PulseTicksReset;
      pending_o    <= 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) pulse_len <= cfg_wdata_i;
      if (out_valid_i && !out_stall_i) check_pin_state(out_data_i);
      if (in_valid_i && !in_stall_i) push_pin_states(in_data_i);
      pending_o <= expected_pins.size();
    end
  end

endmodule

// ----- tb/char_lcd_nibble_writer_tb.sv -----
`timescale 1ns / 100ps
// Top of the char_lcd_nibble_writer testbench: clock, reset, transfer stimulus,
// output back-pressure and the verdict. Depends on lcdnw_pkg, the block itself
// and char_lcd_nibble_writer_checker, which does all prediction and comparison.
module char_lcd_nibble_writer_tb;
  import lcdnw_pkg::*;

  localparam int unsigned MaxIdle    = 14;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned EndPause   = 12;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_we;
  logic [TicksW-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Shared between the stimulus and the result sink: idling switch and the
  // count of long hold-offs asked for.
  logic        rx_idle;
  int unsigned hold_requests;
  int unsigned quiet_cycles;
  int unsigned transfers_sent;
  bit          tx_idle;

  char_lcd_nibble_writer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  char_lcd_nibble_writer_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one transfer. Drop valid only when an idle gap is drawn, so that
  // back-to-back transactions keep valid high without a glitch; then hold the
  // payload until the block takes it.
  task automatic offer_transfer(input logic [7:0] b, input logic d);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= b;
    in_data.is_data   <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transfers_sent++;
  endtask

  // Random transfer; a quarter of them are one of the Turkish letters, so the
  // remap gets hit often, with the flag left random so commands see them too.
  task automatic offer_random_transfer();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0:       b = 8'hC7;
        1:       b = 8'hDD;
        2:       b = 8'hD6;
        3:       b = 8'hDE;
        default: b = 8'hDC;
      endcase
      b[5] = 1'($urandom_range(0, 1));
    end
    offer_transfer(b, 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait until every predicted pin state has come out, plus a
  // short margin, so that the block is idle before the register is touched.
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_pulse_len(input logic [TicksW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result sink: after each accepted pin state, draw a stall length; serve a
  // long hold-off whenever the stimulus asks for one.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_stall    = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (holds_served != hold_requests) begin
          holds_served = hold_requests;
          stall_left   = LongHold;
        end else if (out_valid && !out_stall) begin
          stall_left = rx_idle ? $urandom_range(0, MaxIdle) : 0;
        end
        if (stall_left != 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("char_lcd_nibble_writer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known level before the first edge.
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rx_idle        = 1'b1;
    tx_idle        = 1'b1;
    hold_requests  = 0;
    transfers_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset pulse length: command extremes and typical
    // commands, every Turkish letter as data, their neighbours, and letters
    // sent as commands, which must pass unchanged.
    offer_transfer(8'h00, 1'b0);
    offer_transfer(8'hFF, 1'b0);
    offer_transfer(8'h28, 1'b0);
    offer_transfer(8'h0C, 1'b0);
    offer_transfer(8'h01, 1'b0);
    offer_transfer(8'hC7, 1'b1);
    offer_transfer(8'hE7, 1'b1);
    offer_transfer(8'hDD, 1'b1);
    offer_transfer(8'hFD, 1'b1);
    offer_transfer(8'hD6, 1'b1);
    offer_transfer(8'hF6, 1'b1);
    offer_transfer(8'hDE, 1'b1);
    offer_transfer(8'hFE, 1'b1);
    offer_transfer(8'hDC, 1'b1);
    offer_transfer(8'hFC, 1'b1);
    offer_transfer(8'h00, 1'b1);
    offer_transfer(8'hFF, 1'b1);
    offer_transfer(8'h41, 1'b1);
    offer_transfer(8'hC6, 1'b1);
    offer_transfer(8'hC8, 1'b1);
    offer_transfer(8'hC7, 1'b0);
    offer_transfer(8'hFC, 1'b0);

    // Zero pulse length: enable and settle states must report no hold. Run
    // this stretch with no idling on either side.
    drain_block();
    write_pulse_len('0);
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    repeat (20) offer_random_transfer();

    // Full-scale pulse length, with a long output hold-off while the sender
    // pushes without gaps, so the queue fills and the input stalls.
    drain_block();
    write_pulse_len('1);
    rx_idle       <= 1'b1;
    hold_requests <= hold_requests + 1;
    repeat (20) offer_random_transfer();

    // Shortest legal pulse, random idling on both sides.
    drain_block();
    write_pulse_len(20'd1);
    tx_idle = 1'b1;
    repeat (25) offer_random_transfer();

    // A random mid-range pulse length to finish.
    drain_block();
    write_pulse_len(TicksW'($urandom_range(2, 20'hFFFFE)));
    repeat (13) offer_random_transfer();

    drain_block();
    repeat (EndPause) @(posedge clk);

    $display("Sent %0d transfers and checked %0d pin states over five pulse lengths,",
             transfers_sent, checked);
    $display("zero and full scale included, with random idling and a %0d-cycle output hold.",
             LongHold);
    if (fail_count == 0 && pending == 0) begin
      $display("char_lcd_nibble_writer_tb OK");
    end else begin
      $display("char_lcd_nibble_writer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lcdnw_pkg.sv
sv/lcdnw_front.sv
sv/lcdnw_queue.sv
sv/lcdnw_back.sv
sv/char_lcd_nibble_writer.sv
tb/char_lcd_nibble_writer_checker.sv
tb/char_lcd_nibble_writer_tb.sv
